@@ rtl/core/ic_pkg.sv @@
`default_nettype none

package ic_pkg;

  localparam int unsigned MaxLen = 1024;
  localparam int unsigned IdxW   = $clog2(MaxLen + 1);
  localparam int unsigned CntW   = $clog2(MaxLen);
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 19;
  localparam int unsigned SumW   = CountW + 1;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   is_last;
  } ic_in_t;

  typedef struct packed {
    logic [CountW-1:0] inversion_count;
    logic              overflow;
  } ic_out_t;

  // Token that walks down the chain, one cell per cycle while the chain advances
  typedef struct packed {
    logic                   valid;
    logic                   keep;
    logic                   last;
    logic                   ovf;
    logic [IdxW-1:0]        idx;
    logic [CntW-1:0]        count;
    logic signed [ValW-1:0] value;
  } ic_tok_t;

endpackage

`default_nettype wire

@@ rtl/core/ic_cell.sv @@
`default_nettype none

module ic_cell (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   adv_i,
  input  wire logic [ic_pkg::IdxW-1:0] cell_idx_i,
  input  wire ic_pkg::ic_tok_t        tok_i,
  output ic_pkg::ic_tok_t             tok_o
);

  logic signed [ic_pkg::ValW-1:0] held_q;
  ic_pkg::ic_tok_t                tok_q, tok_d;
  logic                           hit;
  logic                           store;

  // Only cells filled earlier in the same sequence sit below the token's index
  assign hit   = tok_i.valid && tok_i.keep && (cell_idx_i < tok_i.idx) && (held_q > tok_i.value);
  assign store = tok_i.valid && tok_i.keep && (cell_idx_i == tok_i.idx);

  always_comb begin
    tok_d       = tok_i;
    tok_d.count = tok_i.count + ic_pkg::CntW'(hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && store) begin
      held_q <= tok_i.value;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

@@ rtl/core/ic_accum.sv @@
`default_nettype none

module ic_accum (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ic_pkg::ic_tok_t tok_i,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output ic_pkg::ic_out_t      out_data_o,
  output logic                 adv_o
);

  logic [ic_pkg::CountW-1:0] total_q;
  logic [ic_pkg::SumW-1:0]   sum;
  logic [ic_pkg::CountW-1:0] sat;
  logic                      out_valid_q;
  ic_pkg::ic_out_t           out_q;

  // Hold the whole chain while a result waits
  assign adv_o = !out_valid_q || out_ready_i;

  assign sum = {1'b0, total_q} + ic_pkg::SumW'(tok_i.count);
  assign sat = (sum > ic_pkg::SumW'(ic_pkg::CountMax)) ? ic_pkg::CountMax
                                                        : sum[ic_pkg::CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= tok_i.valid && tok_i.last;
      if (tok_i.valid) begin
        total_q <= tok_i.last ? '0 : sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && tok_i.valid && tok_i.last) begin
      out_q.inversion_count <= sat;
      out_q.overflow        <= tok_i.ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/inversion_counter_core.sv @@
// Channel | Signals                          | Direction | Item
// in      | in_valid_i in_ready_o in_data_i   | input     | value, is_last
// out     | out_valid_o out_ready_i out_data_o | output    | inversion_count, overflow
//
// One item is accepted per cycle while the output register is free.
// Each item walks a chain of MaxLen compare cells, one cell per cycle while the
// chain advances; the result is registered in the accumulator after the last cell.
// Reset clears the chain's tokens, the item counter and the running total;
// the held values are not cleared, only cells written in the current
// sequence are compared. A result not taken stalls the whole chain and input.
`default_nettype none

module inversion_counter_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ic_pkg::ic_in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output ic_pkg::ic_out_t      out_data_o
);

  logic                    adv;
  logic                    take;
  logic                    room;
  logic [ic_pkg::IdxW-1:0] seen_q;
  logic                    ovf_q;
  ic_pkg::ic_tok_t         tok [ic_pkg::MaxLen+1];

  assign in_ready_o = adv;
  assign take       = in_valid_i && adv;
  assign room       = seen_q < ic_pkg::IdxW'(ic_pkg::MaxLen);

  always_comb begin
    tok[0].valid = take;
    tok[0].keep  = room;
    tok[0].last  = in_data_i.is_last;
    tok[0].ovf   = ovf_q || !room;
    tok[0].idx   = seen_q;
    tok[0].count = '0;
    tok[0].value = in_data_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      ovf_q  <= 1'b0;
    end else if (take) begin
      if (in_data_i.is_last) begin
        seen_q <= '0;
        ovf_q  <= 1'b0;
      end else if (room) begin
        seen_q <= seen_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  for (genvar k = 0; k < ic_pkg::MaxLen; k++) begin : g_cell
    ic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (ic_pkg::IdxW'(k)),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1])
    );
  end

  ic_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok[ic_pkg::MaxLen]),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .adv_o       (adv)
  );

endmodule

`default_nettype wire

@@ rtl/core/ic_checker.sv @@
`default_nettype none

module ic_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_o,
  input wire ic_pkg::ic_in_t  in_data_i,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire ic_pkg::ic_out_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Input is ready exactly when the output side can move
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not track output stall");

  // A new result only appears once the chain has advanced
  a_rise_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared while chain was held");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) && rst_ni |-> !out_valid_o)
    else $error("result valid right after reset");

  logic unused_in;
  assign unused_in = in_valid_i ^ in_data_i.is_last;

endmodule

bind inversion_counter_core ic_checker u_ic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ dv/tb_inversion_counter_core.sv @@
`timescale 1ns / 100ps

module tb_inversion_counter_core;
  import ic_pkg::*;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   last;
    logic                   typed;
    logic [CountW-1:0]      count;
    logic                   ovf;
  } row_t;

  localparam int DirRows    = 23;
  localparam int RandItems  = 550;
  localparam int HoldCycles = 3000;
  localparam int IdlePct    = 31;

  localparam int unsigned CountCap = CountMax;

  localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;

  // every pair of a strictly falling run of MaxLen, with items dropped past capacity
  localparam ic_out_t FullDescending = '{
    inversion_count: CountW'(MaxLen * (MaxLen - 1) / 2),
    overflow:        1'b1
  };

  localparam row_t Script [DirRows] = '{
    '{32'sd0,  1'b1, 1'b1, 19'd0, 1'b0},
    '{ValMax,  1'b1, 1'b1, 19'd0, 1'b0},
    '{ValMin,  1'b1, 1'b1, 19'd0, 1'b0},
    '{ValMax,  1'b0, 1'b0, 19'd0, 1'b0},
    '{ValMin,  1'b1, 1'b1, 19'd1, 1'b0},
    '{ValMin,  1'b0, 1'b0, 19'd0, 1'b0},
    '{ValMax,  1'b1, 1'b1, 19'd0, 1'b0},
    '{32'sd5,  1'b0, 1'b0, 19'd0, 1'b0},
    '{32'sd5,  1'b0, 1'b0, 19'd0, 1'b0},
    '{32'sd5,  1'b1, 1'b1, 19'd0, 1'b0},
    '{-32'sd1, 1'b0, 1'b0, 19'd0, 1'b0},
    '{32'sd0,  1'b1, 1'b1, 19'd0, 1'b0},
    '{32'sd0,  1'b0, 1'b0, 19'd0, 1'b0},
    '{-32'sd1, 1'b1, 1'b1, 19'd1, 1'b0},
    '{32'sd4,  1'b0, 1'b0, 19'd0, 1'b0},
    '{32'sd3,  1'b0, 1'b0, 19'd0, 1'b0},
    '{32'sd2,  1'b0, 1'b0, 19'd0, 1'b0},
    '{32'sd1,  1'b1, 1'b1, 19'd6, 1'b0},
    '{32'sd3,  1'b0, 1'b0, 19'd0, 1'b0},
    '{-32'sd7, 1'b0, 1'b0, 19'd0, 1'b0},
    '{32'sd3,  1'b0, 1'b0, 19'd0, 1'b0},
    '{32'sd10, 1'b0, 1'b0, 19'd0, 1'b0},
    '{-32'sd7, 1'b1, 1'b0, 19'd0, 1'b0}
  };

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  ic_in_t  in_data   = '0;
  logic    out_ready = 1'b0;
  logic    in_ready;
  logic    out_valid;
  ic_out_t out_data;

  bit          steady       = 1'b0;
  int unsigned failures     = 0;
  int unsigned results_seen = 0;

  // running state of the sequence being counted
  logic signed [ValW-1:0] seq_values [MaxLen];
  int unsigned            seq_len   = 0;
  int unsigned            seq_total = 0;
  logic                   seq_ovf   = 1'b0;
  ic_out_t                expected_totals [$];

  inversion_counter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic tally_item(input ic_in_t item, output ic_out_t res);
    int unsigned greater;
    greater = 0;
    res     = '0;
    if (seq_len < MaxLen) begin
      for (int unsigned k = 0; k < seq_len; k++) begin
        if (seq_values[k] > $signed(item.value)) greater++;
      end
      seq_values[seq_len] = item.value;
      seq_len++;
      // saturate rather than wrap
      if (greater > CountCap - seq_total) seq_total = CountCap;
      else seq_total += greater;
    end else begin
      seq_ovf = 1'b1;
    end
    if (!item.is_last) return 1'b0;
    res.inversion_count = seq_total[CountW-1:0];
    res.overflow        = seq_ovf;
    seq_len   = 0;
    seq_total = 0;
    seq_ovf   = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $signed($urandom_range(8)) - 4;
      2: begin
        case ($urandom_range(3))
          0: return ValMax;
          1: return ValMin;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $signed($urandom_range(255)) - 128;
    endcase
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic offer(input ic_in_t item, input logic typed, input ic_out_t typed_res);
    ic_out_t res;
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (tally_item(item, res)) expected_totals.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Hold the input until every outstanding total has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_totals.size() != 0);
  endtask

  initial begin : stimulus
    ic_in_t      item;
    ic_out_t     want;
    int unsigned sent;
    int unsigned len;
    bit          long_done;
    sent      = 0;
    long_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirRows; i++) begin
      item.value           = Script[i].value;
      item.is_last         = Script[i].last;
      want.inversion_count = Script[i].count;
      want.overflow        = Script[i].ovf;
      offer(item, Script[i].typed, want);
    end
    drain();

    want = '0;
    while (sent < RandItems) begin
      if (!long_done && sent >= 200) begin
        drain();
        // strictly falling run past capacity: largest count, then dropped items
        for (int k = 0; k < MaxLen + 3; k++) begin
          item.value   = 32'sd1000 - k;
          item.is_last = (k == MaxLen + 2);
          offer(item, 1'b1, FullDescending);
        end
        sent += MaxLen + 3;
        long_done = 1'b1;
      end else begin
        len    = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(16, 1);
        steady = (sent >= 60 && sent < 180);
        for (int k = 0; k < len; k++) begin
          item.value   = pick_value();
          item.is_last = (k == len - 1);
          offer(item, 1'b0, want);
        end
        sent += len;
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (expected_totals.size() != 0) @(posedge clk);
    repeat (MaxLen + 16) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : receiver
    int  hold_left;
    bit  held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      // one long hold-off so the chain backs up into the input
      if (!held_once && results_seen >= 10) begin
        held_once = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    ic_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_totals.size() == 0) begin
        $display("%0t: unexpected result: expected none, got count %0d overflow %0b",
                 $time, out_data.inversion_count, out_data.overflow);
        failures++;
      end else begin
        want = expected_totals.pop_front();
        if (out_data.inversion_count !== want.inversion_count) begin
          $display("%0t: inversion_count mismatch: expected %0d, got %0d",
                   $time, want.inversion_count, out_data.inversion_count);
          failures++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch: expected %0b, got %0b",
                   $time, want.overflow, out_data.overflow);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ic_pkg.sv
rtl/core/ic_cell.sv
rtl/core/ic_accum.sv
rtl/core/inversion_counter_core.sv
rtl/core/ic_checker.sv
dv/tb_inversion_counter_core.sv
